FILE: hw/rtl/b32d_pkg.sv
// ----------------------------------------------------------------------------
// b32d_pkg
// Shared types and constants for the base32 decoder.
// ----------------------------------------------------------------------------
package b32d_pkg;

    localparam int unsigned SYM_W   = 8;
    localparam int unsigned VAL_W   = 5;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned LEFT_W  = 7;   // at most seven bits left over
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned ACC_W   = LEFT_W + VAL_W;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADCHAR    = 2'd1;
    localparam logic [STAT_W-1:0] ST_INCOMPLETE = 2'd2;

    // alphabet bounds and offsets
    localparam logic [SYM_W-1:0] LOWER_FIRST = 8'h61;
    localparam logic [SYM_W-1:0] LOWER_LAST  = 8'h7A;
    localparam logic [SYM_W-1:0] UPPER_FIRST = 8'h41;
    localparam logic [SYM_W-1:0] UPPER_LAST  = 8'h5A;
    localparam logic [SYM_W-1:0] DIGIT_FIRST = 8'h32;
    localparam logic [SYM_W-1:0] DIGIT_LAST  = 8'h37;
    localparam logic [SYM_W-1:0] DIGIT_OFS   = 8'h18;   // '2' maps to 26

    typedef struct packed {
        logic              ok;
        logic [VAL_W-1:0]  value;
    } t_sym;

    typedef struct packed {
        logic              vld;
        logic [BYTE_W-1:0] data_byte;
        logic [STAT_W-1:0] status;
        logic              last;
    } t_result;

endpackage

FILE: hw/rtl/b32d_sym_map.sv
// ----------------------------------------------------------------------------
// b32d_sym_map
// Maps one raw character to its 5-bit base32 value, flags bad characters.
// ----------------------------------------------------------------------------
module b32d_sym_map (
    input  logic [b32d_pkg::SYM_W-1:0] i_symbol,
    output b32d_pkg::t_sym             o_sym
);

    logic [b32d_pkg::SYM_W-1:0] w_diff;

    always_comb begin
        w_diff = '0;
        o_sym  = '0;
        if (i_symbol inside {[b32d_pkg::LOWER_FIRST:b32d_pkg::LOWER_LAST]}) begin
            w_diff   = i_symbol - b32d_pkg::LOWER_FIRST;
            o_sym.ok = 1'b1;
        end else if (i_symbol inside {[b32d_pkg::DIGIT_FIRST:b32d_pkg::DIGIT_LAST]}) begin
            w_diff   = i_symbol - b32d_pkg::DIGIT_OFS;
            o_sym.ok = 1'b1;
        end else if (i_symbol inside {[b32d_pkg::UPPER_FIRST:b32d_pkg::UPPER_LAST]}) begin
            w_diff   = i_symbol - b32d_pkg::UPPER_FIRST;
            o_sym.ok = 1'b1;
        end
        o_sym.value = w_diff[b32d_pkg::VAL_W-1:0];
    end

endmodule

FILE: hw/rtl/b32d_core.sv
// ----------------------------------------------------------------------------
// b32d_core
// Leftover register, bit count and discard flag; forms the result of one
// character and updates the state when that character is transferred.
// ----------------------------------------------------------------------------
module b32d_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [b32d_pkg::SYM_W-1:0]  i_symbol,
    input  logic                        i_end_of_text,
    output b32d_pkg::t_result           o_result
);

    b32d_pkg::t_sym               w_sym;
    logic [b32d_pkg::LEFT_W-1:0]  r_bits, n_bits;
    logic [b32d_pkg::CNT_W-1:0]   r_count, n_count;
    logic                         r_discard, n_discard;

    logic [b32d_pkg::ACC_W-1:0]   w_acc, w_shifted, w_mask;
    logic [b32d_pkg::CNT_W:0]     w_sum;
    logic                         w_have;
    logic [b32d_pkg::CNT_W-1:0]   w_cnt;

    b32d_sym_map u_sym_map (
        .i_symbol (i_symbol),
        .o_sym    (w_sym)
    );

    always_comb begin
        w_acc     = {r_bits, w_sym.value};
        w_sum     = {1'b0, r_count} + (b32d_pkg::CNT_W+1)'(b32d_pkg::VAL_W);
        w_have    = w_sum >= (b32d_pkg::CNT_W+1)'(b32d_pkg::BYTE_W);
        w_cnt     = w_have ? w_sum[b32d_pkg::CNT_W-1:0] : w_sum[b32d_pkg::CNT_W-1:0];
        // sum minus eight keeps the low three bits; below eight the sum fits too
        w_shifted = w_acc >> w_cnt;
        w_mask    = (b32d_pkg::ACC_W)'((b32d_pkg::ACC_W)'(1) << w_cnt) - 1'b1;

        n_bits    = r_bits;
        n_count   = r_count;
        n_discard = r_discard;
        o_result  = '0;

        if (r_discard) begin
            if (i_end_of_text) begin
                n_discard = 1'b0;
                n_bits    = '0;
                n_count   = '0;
            end
        end else if (!w_sym.ok) begin
            n_bits          = '0;
            n_count         = '0;
            n_discard       = !i_end_of_text;
            o_result.vld    = 1'b1;
            o_result.status = b32d_pkg::ST_BADCHAR;
            o_result.last   = i_end_of_text;
        end else if (i_end_of_text) begin
            n_bits        = '0;
            n_count       = '0;
            o_result.vld  = 1'b1;
            o_result.last = 1'b1;
            if (w_cnt != '0) begin
                o_result.status = b32d_pkg::ST_INCOMPLETE;
            end else begin
                o_result.status    = b32d_pkg::ST_OK;
                o_result.data_byte = w_shifted[b32d_pkg::BYTE_W-1:0];
            end
        end else begin
            n_bits    = w_acc[b32d_pkg::LEFT_W-1:0] & w_mask[b32d_pkg::LEFT_W-1:0];
            n_count   = w_cnt;
            if (w_have) begin
                o_result.vld       = 1'b1;
                o_result.status    = b32d_pkg::ST_OK;
                o_result.data_byte = w_shifted[b32d_pkg::BYTE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits    <= '0;
            r_count   <= '0;
            r_discard <= 1'b0;
        end else if (i_accept) begin
            r_bits    <= n_bits;
            r_count   <= n_count;
            r_discard <= n_discard;
        end
    end

    // bits above the count are always clear
    a_bits_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bits & ~((b32d_pkg::LEFT_W)'(((b32d_pkg::ACC_W)'(1) << r_count) - 1'b1))) == '0)
        else $error("leftover bits beyond count");

    // a message end always leaves an empty, non-discarding state
    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_end_of_text |=> r_count == '0 && r_bits == '0 && !r_discard)
        else $error("state not cleared at message end");

    // while discarding nothing is produced
    a_discard_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_discard |-> !o_result.vld)
        else $error("result while discarding");

endmodule

FILE: hw/rtl/base32_decoder_unit.sv
// ----------------------------------------------------------------------------
// base32_decoder_unit
// Streaming base32 decoder, one character per transfer, bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one character per transfer in s_axis_tdata[7:0];
//   s_axis_tlast marks the final character of a message.
//   Master stream carries zero or one result per character: the decoded byte
//   in m_axis_tdata[7:0], the status in m_axis_tuser[1:0] (0 ok, 1 bad
//   character, 2 incomplete final group) and m_axis_tlast on the result of
//   the final character. On an error the data byte reads zero.
//   After a bad character the rest of that message is dropped silently.
// Timing: a result is registered, shown in the cycle after its character is transferred.
// Throughput: one character per cycle unless the receiver stalls; the state
//   update is a 12-bit shift and mask between the leftover and output registers.
// Reset: synchronous, active low; clears the leftover bits, count, discard
//   flag and the output valid.
// Stalls: s_axis_tready is high while the output register is empty or being
//   emptied in the same cycle, so a held-up receiver stalls the input after
//   one pending result.
// ----------------------------------------------------------------------------
module base32_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] symbol
    input  logic       s_axis_tlast,   // end_of_text

    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_byte
    output logic [1:0] m_axis_tuser,   // [1:0] status
    output logic       m_axis_tlast    // last
);

    logic              w_accept;
    b32d_pkg::t_result w_result;

    logic                          r_out_vld;
    logic [b32d_pkg::BYTE_W-1:0]   r_out_byte;
    logic [b32d_pkg::STAT_W-1:0]   r_out_stat;
    logic                          r_out_last;

    // take a character whenever the output slot is free or draining
    assign s_axis_tready = !r_out_vld || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    b32d_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_symbol      (s_axis_tdata),
        .i_end_of_text (s_axis_tlast),
        .o_result      (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_accept) begin
            r_out_vld <= w_result.vld;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept && w_result.vld) begin
            r_out_byte <= w_result.data_byte;
            r_out_stat <= w_result.status;
            r_out_last <= w_result.last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = r_out_stat;
    assign m_axis_tlast  = r_out_last;

    // incomplete group is only ever reported on the final character
    a_incomplete_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_stat == b32d_pkg::ST_INCOMPLETE |-> r_out_last)
        else $error("incomplete status without last");

    // error results carry a zero byte
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_stat != b32d_pkg::ST_OK |-> r_out_byte == '0)
        else $error("error result with nonzero data");

    // a stalled result holds still until it is transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !m_axis_tready |=> r_out_vld && $stable(r_out_byte)
            && $stable(r_out_stat) && $stable(r_out_last))
        else $error("stalled result changed");

endmodule

FILE: verif/base32_decoder_checker.sv
// ----------------------------------------------------------------------------
// base32_decoder_checker
// Watches both stream channels of the base32 decoder, predicts the decoded
// bytes and status of every character transfer, and compares each result
// transfer with the oldest prediction. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
module base32_decoder_checker
    import b32d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] symbol
    input  logic       s_axis_tlast,   // end_of_text

    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // [7:0] data_byte
    input  logic [1:0] m_axis_tuser,   // [1:0] status
    input  logic       m_axis_tlast,   // last

    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [STAT_W-1:0] status;
        logic              last;
    } t_decoded;

    t_decoded          decoded_q[$];
    logic [LEFT_W-1:0] spare_bits  = '0;
    logic [CNT_W-1:0]  spare_count = '0;
    logic              dropping    = 1'b0;

    // top bit set: character outside the alphabet
    function automatic logic [VAL_W:0] char_value(input logic [SYM_W-1:0] c);
        logic [SYM_W-1:0] ofs;
        if (c >= LOWER_FIRST && c <= LOWER_LAST)
            ofs = c - LOWER_FIRST;
        else if (c >= UPPER_FIRST && c <= UPPER_LAST)
            ofs = c - UPPER_FIRST;
        else if (c >= DIGIT_FIRST && c <= DIGIT_LAST)
            ofs = c - DIGIT_OFS;
        else
            return {1'b1, {VAL_W{1'b0}}};
        return {1'b0, ofs[VAL_W-1:0]};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    task automatic decode_char(input logic [SYM_W-1:0] c, input logic eot);
        logic [VAL_W:0]    sv;
        logic [ACC_W-1:0]  acc;
        logic [BYTE_W-1:0] out_byte;
        logic              have_byte;
        int                cnt;
        // rest of a broken message is ignored until its final character
        if (dropping) begin
            if (eot) begin
                dropping    = 1'b0;
                spare_bits  = '0;
                spare_count = '0;
            end
            return;
        end
        sv = char_value(c);
        if (sv[VAL_W]) begin
            spare_bits  = '0;
            spare_count = '0;
            dropping    = !eot;
            decoded_q.push_back('{'0, ST_BADCHAR, eot});
            return;
        end
        acc       = {spare_bits, sv[VAL_W-1:0]};
        cnt       = spare_count + VAL_W;
        have_byte = 1'b0;
        out_byte  = '0;
        if (cnt >= BYTE_W) begin
            cnt       = cnt - BYTE_W;
            out_byte  = (BYTE_W)'(acc >> cnt);
            have_byte = 1'b1;
        end
        acc = acc & ((12'd1 << cnt) - 12'd1);
        if (eot) begin
            spare_bits  = '0;
            spare_count = '0;
            // leftover bits at the end replace the byte with an error
            if (cnt != 0)
                decoded_q.push_back('{'0, ST_INCOMPLETE, 1'b1});
            else
                decoded_q.push_back('{out_byte, ST_OK, 1'b1});
            return;
        end
        spare_bits  = acc[LEFT_W-1:0];
        spare_count = cnt[CNT_W-1:0];
        if (have_byte)
            decoded_q.push_back('{out_byte, ST_OK, 1'b0});
    endtask

    always @(posedge i_clk) begin
        t_decoded want;
        if (!i_rst_n) begin
            spare_bits  = '0;
            spare_count = '0;
            dropping    = 1'b0;
            decoded_q.delete();
        end else begin
            // result first: it always belongs to an earlier character
            if (m_axis_tvalid && m_axis_tready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("result with none pending, data", m_axis_tdata, -1);
                end else begin
                    want = decoded_q.pop_front();
                    if (m_axis_tdata !== want.data_byte)
                        report_mismatch("data_byte", m_axis_tdata, want.data_byte);
                    if (m_axis_tuser !== want.status)
                        report_mismatch("status", m_axis_tuser, want.status);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last", m_axis_tlast, want.last);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_char(s_axis_tdata, s_axis_tlast);
        end
        o_pending = decoded_q.size();
    end

endmodule

FILE: verif/base32_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// base32_decoder_unit_test
// Drives base32 text into the decoder: a directed set of alphabet edges,
// bad characters and message endings, then random messages with occasional
// noise characters. Both stream sides pause at random; a checker module
// predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module base32_decoder_unit_test;
    import b32d_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int CYCLE_LIMIT  = 200000;  // well over the slowest legal run
    localparam int DRAIN_CYCLES = 8;       // result is registered, shown in the cycle after its character
    localparam int RANDOM_CHARS = 1550;
    localparam int IDLE_PCT     = 8;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] symbol
    logic       s_axis_tlast  = 1'b0;    // end_of_text
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b1;
    logic [7:0] m_axis_tdata;            // [7:0] data_byte
    logic [1:0] m_axis_tuser;            // [1:0] status
    logic       m_axis_tlast;            // last

    int fail_count;
    int pending;
    int cycle_count = 0;
    bit gaps_on     = 1'b1;   // random idling on both sides
    int counted     = 0;      // random characters transferred so far

    always #(HALF_PERIOD) i_clk = ~i_clk;

    base32_decoder_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    base32_decoder_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // receiver back-pressure, changed only on the falling edge
    always @(negedge i_clk) begin
        m_axis_tready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
    end

    // watchdog: a hung handshake or a missing result ends here
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL base32_decoder_unit");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    // tvalid is left high on return, so back-to-back characters see no gap.
    task automatic send_char(input logic [7:0] c, input logic eot);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eot;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // whole message, end flag on the final character
    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], i == txt.len() - 1);
    endtask

    function automatic logic [7:0] random_char();
        int v;
        v = $urandom_range(31);
        if (v >= 26)
            return 8'(DIGIT_FIRST + v - 26);
        else if ($urandom_range(1) != 0)
            return 8'(UPPER_FIRST + v);
        else
            return 8'(LOWER_FIRST + v);
    endfunction

    initial begin
        int len;
        int bad_at;
        logic [7:0] c;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part ---
        send_text("a");          // five bits only at the end: incomplete group
        send_text("aZ27zA7a");   // alphabet edges, forty bits: final byte with last
        send_text("ab1cd");      // bad char mid-message, rest dropped until the end
        send_text("@");          // bad char as the final character
        send_text("ab");         // byte then two bits over at the end: error wins
        // characters just above the digit and upper ranges, either side of the lower range, and the byte extremes
        send_char(8'h60, 1'b1);
        send_char(8'h7B, 1'b1);
        send_char(8'h38, 1'b1);
        send_char(8'h5B, 1'b1);
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);

        // --- random messages ---
        while (counted < RANDOM_CHARS) begin
            // a stretch with no pauses on either side
            gaps_on = !(counted >= 500 && counted < 800);
            // whole groups of eight characters end cleanly; other lengths leave bits unless a multiple of eight
            if ($urandom_range(9) < 4)
                len = 8 * $urandom_range(1, 3);
            else
                len = $urandom_range(1, 20);
            bad_at = ($urandom_range(99) < 15) ? $urandom_range(len - 1) : -1;
            for (int i = 0; i < len; i++) begin
                c = (i == bad_at) ? 8'($urandom_range(255)) : random_char();
                send_char(c, i == len - 1);
                counted++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0)
            $display("PASS base32_decoder_unit");
        else
            $display("FAIL base32_decoder_unit");
        $finish;
    end

endmodule

FILE: base32_decoder_unit.f
hw/rtl/b32d_pkg.sv
hw/rtl/b32d_sym_map.sv
hw/rtl/b32d_core.sv
hw/rtl/base32_decoder_unit.sv
verif/base32_decoder_checker.sv
verif/base32_decoder_unit_test.sv
